// File: rtl/rgba_ab_pkg.sv
// ----------------------------------------------------------------------------
// rgba_ab_pkg
// Shared types and constants of the source-over RGBA alpha blend pipeline.
// ----------------------------------------------------------------------------
package rgba_ab_pkg;

   localparam int NUM_COLORS = 3;

   localparam logic [7:0] CH_MAX = 8'd255;
   localparam longint unsigned CH_MAX_SQ = 64'd65025;
   localparam int ALPHA_SHIFT = 8;

   localparam int FRONT_SHIFT = 24;
   localparam int FRONT_RECIP_W = 17;
   localparam int FRONT_PROD_W = 16 + FRONT_RECIP_W;
   localparam logic [FRONT_RECIP_W-1:0] FRONT_RECIP =
      FRONT_RECIP_W'(((64'd1 << FRONT_SHIFT) + 64'd254) / 64'd255);

   localparam int BACK_SHIFT = 40;
   localparam int BACK_RECIP_W = 25;
   localparam int BACK_PROD_W = 24 + BACK_RECIP_W;
   localparam logic [BACK_RECIP_W-1:0] BACK_RECIP =
      BACK_RECIP_W'(((64'd1 << BACK_SHIFT) + CH_MAX_SQ - 64'd1) / CH_MAX_SQ);

   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      logic [NUM_COLORS-1:0][15:0] front_prod;
      logic [NUM_COLORS-1:0][15:0] back_prod;
      logic [7:0]                  inv_alpha;
      logic [7:0]                  src_alpha;
      logic [15:0]                 alpha_prod;
   } prod_type;

   typedef struct packed {
      logic [NUM_COLORS-1:0][7:0]  front_q;
      logic [NUM_COLORS-1:0][23:0] back_num;
      logic [7:0]                  alpha_out;
   } scale_type;

   typedef struct packed {
      logic [NUM_COLORS-1:0][7:0] front_q;
      logic [NUM_COLORS-1:0][7:0] back_q;
      logic [7:0]                 alpha_out;
   } recip_type;

endpackage

// File: rtl/rgba_alpha_blend_top.sv
// ----------------------------------------------------------------------------
// rgba_alpha_blend_top
// Source-over alpha blend of one RGBA source pixel onto a destination pixel.
// ----------------------------------------------------------------------------
// The req_ channel carries one request per pixel: the source pixel and the
// destination pixel read from the frame buffer. The rsp_ channel returns the
// blended pixel. Both channels use valid/ready.
// Four register stages: 8x8 products, divide-by-255 and weight multiply,
// divide-by-65025 reciprocal multiply, then sum into the output register.
// A request accepted on req_ passes through the prod, scale, recip and merge
// registers in order to rsp_. Throughput is one pixel per clock while
// rsp_ready stays high.
// An opaque source passes through, since its destination term is zero.
// Synchronous reset empties all stages; req_ready is high right after.
// When the receiver stalls, each full stage holds its request and req_ready
// falls once every stage is full; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rgba_alpha_blend_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rgba_ab_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rgba_ab_pkg::rsp_type rsp_data
);
   import rgba_ab_pkg::*;

   logic      prod_vld, prod_ready;
   prod_type  prod_data;
   logic      scale_vld, scale_ready;
   scale_type scale_data;
   logic      recip_vld, recip_ready;
   recip_type recip_data;
   logic      merge_ready;

   rgba_ab_prod u_prod (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (req_valid),
      .in_data    (req_data),
      .up_ready   (req_ready),
      .down_ready (prod_ready),
      .out_vld    (prod_vld),
      .out_data   (prod_data)
   );

   rgba_ab_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (prod_vld),
      .in_data    (prod_data),
      .up_ready   (prod_ready),
      .down_ready (scale_ready),
      .out_vld    (scale_vld),
      .out_data   (scale_data)
   );

   rgba_ab_recip u_recip (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (scale_vld),
      .in_data    (scale_data),
      .up_ready   (scale_ready),
      .down_ready (recip_ready),
      .out_vld    (recip_vld),
      .out_data   (recip_data)
   );

   rgba_ab_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (recip_vld),
      .in_data    (recip_data),
      .up_ready   (merge_ready),
      .down_ready (rsp_ready),
      .out_vld    (rsp_valid),
      .out_data   (rsp_data)
   );

   assign recip_ready = merge_ready;

   property p_empty_out_ready;
      @(posedge clock) disable iff (reset)
         !rsp_valid |-> req_ready;
   endproperty
   a_empty_out_ready: assert property (p_empty_out_ready)
      else $error("request stalled while output register is empty");

   property p_drain_ready;
      @(posedge clock) disable iff (reset)
         rsp_ready |-> req_ready;
   endproperty
   a_drain_ready: assert property (p_drain_ready)
      else $error("request stalled while receiver is ready");

   property p_opaque_alpha;
      @(posedge clock) disable iff (reset)
         (prod_vld && prod_ready && prod_data.src_alpha == CH_MAX)
            |=> (scale_data.alpha_out == CH_MAX);
   endproperty
   a_opaque_alpha: assert property (p_opaque_alpha)
      else $error("opaque source did not keep full alpha");

endmodule

// File: rtl/rgba_ab_prod.sv
// ----------------------------------------------------------------------------
// rgba_ab_prod
// First stage: 8x8 products of the color channels with their alphas.
// ----------------------------------------------------------------------------
module rgba_ab_prod (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  rgba_ab_pkg::req_type  in_data,
   output logic                  up_ready,
   input  logic                  down_ready,
   output logic                  out_vld,
   output rgba_ab_pkg::prod_type out_data
);
   import rgba_ab_pkg::*;

   logic     vld_ff;
   prod_type data_ff;
   prod_type data_in;
   logic [NUM_COLORS-1:0][7:0] src_color;
   logic [NUM_COLORS-1:0][7:0] dst_color;

   always_comb begin
      src_color = {in_data.src_red, in_data.src_green, in_data.src_blue};
      dst_color = {in_data.dst_red, in_data.dst_green, in_data.dst_blue};
      data_in.inv_alpha  = CH_MAX - in_data.src_alpha;
      data_in.src_alpha  = in_data.src_alpha;
      data_in.alpha_prod = 16'(in_data.dst_alpha) * 16'(data_in.inv_alpha);
      for (int i = 0; i < NUM_COLORS; i++) begin
         data_in.front_prod[i] = 16'(src_color[i]) * 16'(in_data.src_alpha);
         data_in.back_prod[i]  = 16'(dst_color[i]) * 16'(in_data.dst_alpha);
      end
   end

   assign up_ready = !vld_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_vld) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

// File: rtl/rgba_ab_scale.sv
// ----------------------------------------------------------------------------
// rgba_ab_scale
// Second stage: source term divided by 255, destination term times 255-alpha,
// and the blended alpha.
// ----------------------------------------------------------------------------
module rgba_ab_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  rgba_ab_pkg::prod_type  in_data,
   output logic                   up_ready,
   input  logic                   down_ready,
   output logic                   out_vld,
   output rgba_ab_pkg::scale_type out_data
);
   import rgba_ab_pkg::*;

   logic      vld_ff;
   scale_type data_ff;
   scale_type data_in;
   logic [NUM_COLORS-1:0][FRONT_PROD_W-1:0] front_full;

   always_comb begin
      data_in.alpha_out = in_data.src_alpha + in_data.alpha_prod[15:ALPHA_SHIFT];
      for (int i = 0; i < NUM_COLORS; i++) begin
         front_full[i] = FRONT_PROD_W'(in_data.front_prod[i]) * FRONT_PROD_W'(FRONT_RECIP);
         data_in.front_q[i]  = front_full[i][FRONT_SHIFT+7:FRONT_SHIFT];
         data_in.back_num[i] = 24'(in_data.back_prod[i]) * 24'(in_data.inv_alpha);
      end
   end

   assign up_ready = !vld_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_vld) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

// File: rtl/rgba_ab_recip.sv
// ----------------------------------------------------------------------------
// rgba_ab_recip
// Third stage: destination term divided by 65025 through a reciprocal
// multiply.
// ----------------------------------------------------------------------------
module rgba_ab_recip (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  rgba_ab_pkg::scale_type in_data,
   output logic                   up_ready,
   input  logic                   down_ready,
   output logic                   out_vld,
   output rgba_ab_pkg::recip_type out_data
);
   import rgba_ab_pkg::*;

   logic      vld_ff;
   recip_type data_ff;
   recip_type data_in;
   logic [NUM_COLORS-1:0][BACK_PROD_W-1:0] back_full;

   always_comb begin
      data_in.front_q   = in_data.front_q;
      data_in.alpha_out = in_data.alpha_out;
      for (int i = 0; i < NUM_COLORS; i++) begin
         back_full[i] = BACK_PROD_W'(in_data.back_num[i]) * BACK_PROD_W'(BACK_RECIP);
         data_in.back_q[i] = back_full[i][BACK_SHIFT+7:BACK_SHIFT];
      end
   end

   assign up_ready = !vld_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_vld) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

   property p_stall_holds;
      @(posedge clock) disable iff (reset)
         (vld_ff && !down_ready) |=> (vld_ff && $stable(data_ff));
   endproperty
   a_stall_holds: assert property (p_stall_holds)
      else $error("recip stage lost or changed a stalled request");

endmodule

// File: rtl/rgba_ab_merge.sv
// ----------------------------------------------------------------------------
// rgba_ab_merge
// Last stage: sum of source and destination terms into the output register.
// ----------------------------------------------------------------------------
module rgba_ab_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  rgba_ab_pkg::recip_type in_data,
   output logic                   up_ready,
   input  logic                   down_ready,
   output logic                   out_vld,
   output rgba_ab_pkg::rsp_type   out_data
);
   import rgba_ab_pkg::*;

   logic    vld_ff;
   rsp_type data_ff;
   rsp_type data_in;
   logic [NUM_COLORS-1:0][7:0] color_sum;

   always_comb begin
      for (int i = 0; i < NUM_COLORS; i++) begin
         color_sum[i] = in_data.front_q[i] + in_data.back_q[i];
      end
      data_in.out_red   = color_sum[2];
      data_in.out_green = color_sum[1];
      data_in.out_blue  = color_sum[0];
      data_in.out_alpha = in_data.alpha_out;
   end

   assign up_ready = !vld_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_vld) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

// File: verif/tb_rgba_alpha_blend_top.sv
// ----------------------------------------------------------------------------
// tb_rgba_alpha_blend_top
// Self-checking bench for the source-over RGBA alpha blend pipeline.
// ----------------------------------------------------------------------------
// A short table of hand-picked pixels goes first: all-zero, all-ones, opaque
// sources, fully transparent sources and alternating bit patterns. Random
// pixels follow, with extra weight on opaque, transparent and extreme
// alphas. A model of the blend predicts each accepted request that the table
// gives no result for; each result is compared with it field by field. Both
// sides idle in random bursts, except near the end of the run. Once, the
// receiver holds off long enough to fill the pipeline and stall the input.
// ----------------------------------------------------------------------------
module tb_rgba_alpha_blend_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rgba_ab_pkg::req_type;
   import rgba_ab_pkg::rsp_type;

   localparam int unsigned OPAQUE = 255;
   localparam int unsigned FULL_SQ = 65025;
   localparam int unsigned ALPHA_SHR = 8;
   localparam int RANDOM_PIXELS = 1084;
   localparam int QUIET_TAIL = 150;
   localparam int HOLD_AT = 200;
   localparam int LONG_HOLD = 64;
   localparam int DRAIN_CYCLES = 16;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic    known;
      req_type pixel;
      rsp_type want;
   } blend_vector_t;

   localparam blend_vector_t DIRECTED [16] = '{
      '{1'b1, 64'h00000000_00000000, 32'h00000000},
      '{1'b1, 64'hffffffff_ffffffff, 32'hffffffff},
      '{1'b1, 64'h123456ff_aabbcc11, 32'h123456ff},
      '{1'b1, 64'h000000ff_ffffffff, 32'h000000ff},
      '{1'b1, 64'hffffff00_102030ff, 32'h102030fe},
      '{1'b1, 64'hffffff00_ffffff00, 32'h00000000},
      '{1'b1, 64'hffffff00_ffffffff, 32'hfffffffe},
      '{1'b0, 64'hfffffffe_ffffffff, 32'h00000000},
      '{1'b0, 64'h808080fe_ffffff00, 32'h00000000},
      '{1'b0, 64'hffffff01_ffffffff, 32'h00000000},
      '{1'b0, 64'hc0c0c080_40404080, 32'h00000000},
      '{1'b0, 64'h8040207f_01020408, 32'h00000000},
      '{1'b0, 64'haa55aa55_55aa55aa, 32'h00000000},
      '{1'b0, 64'h55aa55aa_aa55aa55, 32'h00000000},
      '{1'b0, 64'h00000000_ffffff01, 32'h00000000},
      '{1'b1, 64'h010203ff_00000000, 32'h010203ff}
   };

   localparam string FIELD_NAME [4] = '{"out_alpha", "out_blue", "out_green", "out_red"};

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic    pixel_known = 1'b0;
   rsp_type pixel_want = '0;
   bit      idle_on = 1'b1;
   bit      stall_long = 1'b0;

   rsp_type blended_queue [$];
   int      errors = 0;
   int      requests_sent = 0;
   int      opaque_sent = 0;
   int      results_checked = 0;
   int      input_stall_cycles = 0;
   int      stuck_cycles = 0;

   rgba_alpha_blend_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] weighted_channel(input logic [7:0] s, input logic [7:0] d,
                                                   input int unsigned sa,
                                                   input int unsigned da);
      int unsigned front;
      int unsigned back;
      front = (int'(s) * sa) / OPAQUE;
      back = (int'(d) * da * (OPAQUE - sa)) / FULL_SQ;
      return 8'(front + back);
   endfunction

   function automatic rsp_type blend_pixel(input req_type px);
      rsp_type     mixed;
      int unsigned sa;
      int unsigned da;
      sa = px.src_alpha;
      da = px.dst_alpha;
      if (sa == OPAQUE) begin
         mixed.out_red = px.src_red;
         mixed.out_green = px.src_green;
         mixed.out_blue = px.src_blue;
         mixed.out_alpha = px.src_alpha;
      end else begin
         mixed.out_red = weighted_channel(px.src_red, px.dst_red, sa, da);
         mixed.out_green = weighted_channel(px.src_green, px.dst_green, sa, da);
         mixed.out_blue = weighted_channel(px.src_blue, px.dst_blue, sa, da);
         mixed.out_alpha = 8'(sa + ((da * (OPAQUE - sa)) >> ALPHA_SHR));
      end
      return mixed;
   endfunction

   task automatic send_pixel(input req_type px, input logic known, input rsp_type want);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      pixel_known <= known;
      pixel_want <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type          golden;
      logic [3:0][7:0] golden_b;
      logic [3:0][7:0] seen_b;
      if (reset) begin
         stuck_cycles = 0;
      end else begin
         if (req_valid && req_ready) begin
            blended_queue.push_back(pixel_known ? pixel_want : blend_pixel(req_data));
            requests_sent++;
            if (req_data.src_alpha == 8'(OPAQUE)) opaque_sent++;
         end
         if (req_valid && !req_ready) input_stall_cycles++;
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (blended_queue.size() == 0) begin
               $display("%0t: unexpected result %h with no request pending", $time, rsp_data);
               errors++;
            end else begin
               golden = blended_queue.pop_front();
               golden_b = golden;
               seen_b = rsp_data;
               for (int i = 3; i >= 0; i--) begin
                  if (seen_b[i] !== golden_b[i]) begin
                     $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                              FIELD_NAME[i], golden_b[i], seen_b[i]);
                     errors++;
                  end
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cycles = 0;
         else stuck_cycles++;
      end
   end

   initial begin
      wait (stuck_cycles >= WATCHDOG_LIMIT);
      $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (stall_long) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            stall_long = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      req_type     px;
      int unsigned pick;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (DIRECTED[i]) send_pixel(DIRECTED[i].pixel, DIRECTED[i].known, DIRECTED[i].want);
      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if (n == HOLD_AT) stall_long = 1'b1;
         if (n == RANDOM_PIXELS - QUIET_TAIL) idle_on = 1'b0;
         px = {$urandom, $urandom};
         pick = $urandom_range(0, 19);
         if (pick < 5) px.src_alpha = 8'(OPAQUE);
         else if (pick < 7) px.src_alpha = 8'h00;
         else if (pick == 7) px.dst_alpha = 8'h00;
         else if (pick == 8) px.dst_alpha = 8'hff;
         else if (pick == 9) px.src_alpha = 8'hfe;
         send_pixel(px, 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (blended_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Blended %0d pixels (%0d opaque), checked %0d results, %0d errors.",
               requests_sent, opaque_sent, results_checked, errors);
      $display("Input held off by a full pipeline for %0d cycles.", input_stall_cycles);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
